// ===== rtl/core/pcru_pkg.sv =====
// Shared types, constants and helper functions for the polar/cartesian rotate unit.
package pcru_pkg;

   localparam int COORD_W    = 16;
   localparam int RAD_W      = 24;
   localparam int ANG_W      = 16;
   localparam int RAD_FRAC   = 8;
   localparam int INNER_FRAC = 24;
   localparam int STEPS      = 24;
   localparam int STEP_W     = 5;
   localparam int DW         = 44;
   localparam int ZW         = 34;
   localparam int OPW        = 25;
   localparam int MW         = 56;
   localparam int ARC_W      = 30;
   localparam int ADD_W      = COORD_W + 1;

   localparam logic [29:0] GAIN_INV = 30'd652032874;
   localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_W - 1));
   localparam int RAD_MAX   = (1 << RAD_W) - 1;

   localparam logic [2:0] OP_TO_POLAR      = 3'd0;
   localparam logic [2:0] OP_TO_POINT      = 3'd1;
   localparam logic [2:0] OP_ROTATE_POINT  = 3'd2;
   localparam logic [2:0] OP_ROTATE_AROUND = 3'd3;
   localparam logic [2:0] OP_TRANSLATE     = 3'd4;
   localparam logic [2:0] OP_DISTANCE      = 3'd5;

   typedef struct packed {
      logic [2:0]                opcode;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic [RAD_W-1:0]          vertex_radius;
      logic signed [ANG_W-1:0]   vertex_angle;
      logic signed [ANG_W-1:0]   rotation_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_out;
      logic signed [COORD_W-1:0] y_out;
      logic [RAD_W-1:0]          radius_out;
      logic signed [ANG_W-1:0]   angle_out;
      logic                      overflow;
   } rsp_type;

   // CORDIC working vector
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 vec_mode;
   } vec_type;

   // side data that travels alongside the CORDIC vector
   typedef struct packed {
      logic [2:0]              opcode;
      logic                    zero;
      logic signed [ADD_W-1:0] add_x;
      logic signed [ADD_W-1:0] add_y;
   } ctx_type;

   function automatic logic [ARC_W-1:0] arc_value(input logic [STEP_W-1:0] step);
      logic [ARC_W-1:0] a;
      unique case (step)
         5'd0:  a = 30'd536870912;
         5'd1:  a = 30'd316933406;
         5'd2:  a = 30'd167458907;
         5'd3:  a = 30'd85004756;
         5'd4:  a = 30'd42667331;
         5'd5:  a = 30'd21354465;
         5'd6:  a = 30'd10679838;
         5'd7:  a = 30'd5340245;
         5'd8:  a = 30'd2670163;
         5'd9:  a = 30'd1335087;
         5'd10: a = 30'd667544;
         5'd11: a = 30'd333772;
         5'd12: a = 30'd166886;
         5'd13: a = 30'd83443;
         5'd14: a = 30'd41722;
         5'd15: a = 30'd20861;
         5'd16: a = 30'd10430;
         5'd17: a = 30'd5215;
         5'd18: a = 30'd2608;
         5'd19: a = 30'd1304;
         5'd20: a = 30'd652;
         5'd21: a = 30'd326;
         5'd22: a = 30'd163;
         5'd23: a = 30'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

   // round half to even after dropping sh fraction bits
   function automatic logic signed [DW-1:0] round_half_even(input logic signed [DW-1:0] v,
                                                            input int sh);
      logic signed [DW-1:0] q;
      logic [DW-1:0]        rem;
      logic [DW-1:0]        half;
      q    = v >>> sh;
      rem  = DW'(v - (q <<< sh));
      half = DW'(1) << (sh - 1);
      if ((rem > half) || ((rem == half) && q[0])) begin
         q = q + DW'(1);
      end
      return q;
   endfunction

endpackage

// ===== rtl/core/pcru_cordic_stage.sv =====
// One registered CORDIC micro-rotation stage of the rotate unit pipeline.
module pcru_cordic_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [pcru_pkg::STEP_W-1:0] step,
   input  logic                        in_valid,
   input  pcru_pkg::vec_type           in_vec,
   input  pcru_pkg::ctx_type           in_ctx,
   output logic                        out_valid,
   output pcru_pkg::vec_type           out_vec,
   output pcru_pkg::ctx_type           out_ctx
);

   logic                            valid_ff;
   pcru_pkg::vec_type               vec_ff;
   pcru_pkg::ctx_type               ctx_ff;
   pcru_pkg::vec_type               vec_in;
   logic signed [pcru_pkg::DW-1:0]  xs;
   logic signed [pcru_pkg::DW-1:0]  ys;
   logic signed [pcru_pkg::ZW-1:0]  arc;
   logic                            turn_pos;

   always_comb begin
      xs       = in_vec.x >>> step;
      ys       = in_vec.y >>> step;
      arc      = $signed({{(pcru_pkg::ZW - pcru_pkg::ARC_W){1'b0}},
                          pcru_pkg::arc_value(step)});
      // vectoring drives y to zero, rotation drives z to zero
      turn_pos = in_vec.vec_mode ? in_vec.y[pcru_pkg::DW-1] : ~in_vec.z[pcru_pkg::ZW-1];
      vec_in.vec_mode = in_vec.vec_mode;
      if (turn_pos) begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - arc;
      end else begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + arc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
         ctx_ff <= in_ctx;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_ctx   = ctx_ff;

endmodule

// ===== rtl/core/polar_cartesian_rotate_unit_core.sv =====
// Top level of the polar/cartesian conversion and rotation unit.
//
// Usage: present one operation word on req_data with req_valid; it is taken
// when req_valid and req_ready are both high. The operation (to polar, to
// point, rotate point, rotate vertex around an origin, translate, distance)
// is chosen by the opcode field. One result word per operation appears on
// rsp_data with rsp_valid and is taken when rsp_ready is high.
// Pipeline: input prep, gain multiply, quadrant fold, 24 CORDIC stages,
// rounding and saturation, each a registered step after acceptance.
// Throughput: one word per cycle while no stall holds the pipeline; the
// unrolled 24-stage CORDIC pipeline sets this figure, every stage holding one word.
// Reset: clears every stage valid bit; the pipeline empties, no word is
// shown and req_ready rises at once. Payload registers keep stale data.
// Stall: when rsp_ready is low with a word waiting, the whole pipeline
// holds and req_ready drops; nothing is lost or repeated. A word enters
// the output register in the same cycle the previous one leaves.
module polar_cartesian_rotate_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcru_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcru_pkg::rsp_type rsp_data
);

   localparam int DW = pcru_pkg::DW;
   localparam int ZW = pcru_pkg::ZW;

   logic advance;

   // ---------------- stage 1: operand selection ----------------
   logic                               s1_valid_ff;
   logic signed [pcru_pkg::OPW-1:0]    s1_ax_ff, s1_ax_in;
   logic signed [pcru_pkg::OPW-1:0]    s1_ay_ff, s1_ay_in;
   logic signed [pcru_pkg::ANG_W-1:0]  s1_ang_ff, s1_ang_in;
   pcru_pkg::ctx_type                  s1_ctx_ff, s1_ctx_in;
   logic                               s1_vec_ff, s1_vec_in;
   logic signed [pcru_pkg::ADD_W-1:0]  dx, dy;

   // ---------------- stage 2: gain multiply ----------------
   logic                               s2_valid_ff;
   logic signed [DW-1:0]               s2_x_ff, s2_x_in;
   logic signed [DW-1:0]               s2_y_ff, s2_y_in;
   logic signed [pcru_pkg::ANG_W-1:0]  s2_ang_ff;
   pcru_pkg::ctx_type                  s2_ctx_ff;
   logic                               s2_vec_ff;
   logic signed [pcru_pkg::MW-1:0]     prod_x, prod_y;

   // ---------------- stage 3: quadrant fold ----------------
   logic                               s3_valid_ff;
   pcru_pkg::vec_type                  s3_vec_ff, s3_vec_in;
   pcru_pkg::ctx_type                  s3_ctx_ff;
   logic signed [31:0]                 z_rot;
   logic                               fold_rot;

   // ---------------- CORDIC chain ----------------
   logic                               c_valid [0:pcru_pkg::STEPS];
   pcru_pkg::vec_type                  c_vec   [0:pcru_pkg::STEPS];
   pcru_pkg::ctx_type                  c_ctx   [0:pcru_pkg::STEPS];

   // ---------------- stage 4: rounding ----------------
   logic                               s4_valid_ff;
   logic signed [DW-1:0]               s4_x_ff, s4_y_ff, s4_r_ff;
   logic signed [pcru_pkg::ANG_W-1:0]  s4_ang_ff;
   pcru_pkg::ctx_type                  s4_ctx_ff;
   logic [31:0]                        ang_round;
   pcru_pkg::vec_type                  c_last;
   pcru_pkg::ctx_type                  ctx_last;

   // ---------------- stage 5: saturation / output word ----------------
   logic                               s5_valid_ff;
   pcru_pkg::rsp_type                  s5_rsp_ff, s5_rsp_in;
   logic signed [DW:0]                 sum_x, sum_y;
   logic                               use_rot;
   logic                               ovf_x, ovf_y, ovf_r;
   logic signed [pcru_pkg::COORD_W-1:0] sat_x, sat_y;
   logic [pcru_pkg::RAD_W-1:0]         sat_r;

   // advance the whole pipeline unless a finished word is stuck at the output
   assign advance   = ~s5_valid_ff | rsp_ready;
   assign req_ready = advance;

   // ---- stage 1 ----
   always_comb begin
      dx = {req_data.second_x[15], req_data.second_x}
           - {req_data.first_x[15], req_data.first_x};
      dy = {req_data.second_y[15], req_data.second_y}
           - {req_data.first_y[15], req_data.first_y};
      s1_ax_in  = '0;
      s1_ay_in  = '0;
      s1_ang_in = '0;
      s1_vec_in = 1'b0;
      s1_ctx_in.opcode = req_data.opcode;
      s1_ctx_in.zero   = 1'b0;
      s1_ctx_in.add_x  = '0;
      s1_ctx_in.add_y  = '0;
      unique case (req_data.opcode)
         pcru_pkg::OP_TO_POLAR: begin
            s1_ax_in  = pcru_pkg::OPW'(req_data.first_x);
            s1_ay_in  = pcru_pkg::OPW'(req_data.first_y);
            s1_vec_in = 1'b1;
            s1_ctx_in.zero = (req_data.first_x == '0) && (req_data.first_y == '0);
         end
         pcru_pkg::OP_TO_POINT: begin
            s1_ax_in  = $signed({1'b0, req_data.vertex_radius});
            s1_ang_in = req_data.vertex_angle;
         end
         pcru_pkg::OP_ROTATE_POINT: begin
            s1_ax_in  = pcru_pkg::OPW'(req_data.first_x);
            s1_ay_in  = pcru_pkg::OPW'(req_data.first_y);
            s1_ang_in = req_data.rotation_angle;
         end
         pcru_pkg::OP_ROTATE_AROUND: begin
            s1_ax_in  = $signed({1'b0, req_data.vertex_radius});
            s1_ang_in = req_data.vertex_angle + req_data.rotation_angle;
            s1_ctx_in.add_x = pcru_pkg::ADD_W'(req_data.second_x);
            s1_ctx_in.add_y = pcru_pkg::ADD_W'(req_data.second_y);
         end
         pcru_pkg::OP_TRANSLATE: begin
            s1_ctx_in.add_x = pcru_pkg::ADD_W'(req_data.first_x)
                              + pcru_pkg::ADD_W'(req_data.second_x);
            s1_ctx_in.add_y = pcru_pkg::ADD_W'(req_data.first_y)
                              + pcru_pkg::ADD_W'(req_data.second_y);
         end
         pcru_pkg::OP_DISTANCE: begin
            s1_ax_in  = pcru_pkg::OPW'(dx);
            s1_ay_in  = pcru_pkg::OPW'(dy);
            s1_vec_in = 1'b1;
            s1_ctx_in.zero = (dx == '0) && (dy == '0);
         end
         default: begin
            // undefined opcode: all-zero result
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ax_ff  <= s1_ax_in;
         s1_ay_ff  <= s1_ay_in;
         s1_ang_ff <= s1_ang_in;
         s1_ctx_ff <= s1_ctx_in;
         s1_vec_ff <= s1_vec_in;
      end
   end

   // ---- stage 2: scale by inverse gain into 24 fraction bits ----
   always_comb begin
      prod_x = s1_ax_ff * $signed({1'b0, pcru_pkg::GAIN_INV});
      prod_y = s1_ay_ff * $signed({1'b0, pcru_pkg::GAIN_INV});
      if ((s1_ctx_ff.opcode == pcru_pkg::OP_TO_POINT) ||
          (s1_ctx_ff.opcode == pcru_pkg::OP_ROTATE_AROUND)) begin
         // radius carries its own fraction bits
         s2_x_in = DW'(prod_x >>> (30 + pcru_pkg::RAD_FRAC - pcru_pkg::INNER_FRAC));
         s2_y_in = DW'(prod_y >>> (30 + pcru_pkg::RAD_FRAC - pcru_pkg::INNER_FRAC));
      end else begin
         s2_x_in = DW'(prod_x >>> (30 - pcru_pkg::INNER_FRAC));
         s2_y_in = DW'(prod_y >>> (30 - pcru_pkg::INNER_FRAC));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_x_ff   <= s2_x_in;
         s2_y_ff   <= s2_y_in;
         s2_ang_ff <= s1_ang_ff;
         s2_ctx_ff <= s1_ctx_ff;
         s2_vec_ff <= s1_vec_ff;
      end
   end

   // ---- stage 3: bring the vector into the CORDIC convergence range ----
   always_comb begin
      z_rot    = {s2_ang_ff, 16'h0000};
      fold_rot = (z_rot > $signed(32'h4000_0000)) || (z_rot < $signed(32'hC000_0000));
      s3_vec_in.vec_mode = s2_vec_ff;
      if (s2_vec_ff) begin
         // vectoring: left half-plane flips by half a turn
         if (s2_x_ff[DW-1]) begin
            s3_vec_in.x = -s2_x_ff;
            s3_vec_in.y = -s2_y_ff;
            s3_vec_in.z = $signed({2'b00, 32'h8000_0000});
         end else begin
            s3_vec_in.x = s2_x_ff;
            s3_vec_in.y = s2_y_ff;
            s3_vec_in.z = '0;
         end
      end else if (fold_rot) begin
         s3_vec_in.x = -s2_x_ff;
         s3_vec_in.y = -s2_y_ff;
         s3_vec_in.z = ZW'($signed({s2_ang_ff ^ 16'h8000, 16'h0000}));
      end else begin
         s3_vec_in.x = s2_x_ff;
         s3_vec_in.y = s2_y_ff;
         s3_vec_in.z = ZW'(z_rot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_vec_ff <= s3_vec_in;
         s3_ctx_ff <= s2_ctx_ff;
      end
   end

   // ---- unrolled CORDIC: one micro-rotation per stage ----
   assign c_valid[0] = s3_valid_ff;
   assign c_vec[0]   = s3_vec_ff;
   assign c_ctx[0]   = s3_ctx_ff;

   for (genvar i = 0; i < pcru_pkg::STEPS; i++) begin : g_cordic
      pcru_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (pcru_pkg::STEP_W'(i)),
         .in_valid  (c_valid[i]),
         .in_vec    (c_vec[i]),
         .in_ctx    (c_ctx[i]),
         .out_valid (c_valid[i+1]),
         .out_vec   (c_vec[i+1]),
         .out_ctx   (c_ctx[i+1])
      );
   end

   // ---- stage 4: round to output precision ----
   assign c_last    = c_vec[pcru_pkg::STEPS];
   assign ctx_last  = c_ctx[pcru_pkg::STEPS];
   assign ang_round = c_last.z[31:0] + 32'h0000_8000;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= c_valid[pcru_pkg::STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_x_ff   <= pcru_pkg::round_half_even(c_last.x, pcru_pkg::INNER_FRAC);
         s4_y_ff   <= pcru_pkg::round_half_even(c_last.y, pcru_pkg::INNER_FRAC);
         // to_polar keeps radius fraction bits, distance is whole
         if (ctx_last.opcode == pcru_pkg::OP_TO_POLAR) begin
            s4_r_ff <= pcru_pkg::round_half_even(c_last.x,
                          pcru_pkg::INNER_FRAC - pcru_pkg::RAD_FRAC);
         end else begin
            s4_r_ff <= pcru_pkg::round_half_even(c_last.x, pcru_pkg::INNER_FRAC);
         end
         s4_ang_ff <= ang_round[31:16];
         s4_ctx_ff <= ctx_last;
      end
   end

   // ---- stage 5: translate, saturate and form the result word ----
   always_comb begin
      use_rot = (s4_ctx_ff.opcode == pcru_pkg::OP_TO_POINT) ||
                (s4_ctx_ff.opcode == pcru_pkg::OP_ROTATE_POINT) ||
                (s4_ctx_ff.opcode == pcru_pkg::OP_ROTATE_AROUND);
      sum_x = (use_rot ? (DW+1)'(s4_x_ff) : '0) + (DW+1)'(s4_ctx_ff.add_x);
      sum_y = (use_rot ? (DW+1)'(s4_y_ff) : '0) + (DW+1)'(s4_ctx_ff.add_y);

      ovf_x = 1'b1;
      if (sum_x > pcru_pkg::COORD_MAX) begin
         sat_x = pcru_pkg::COORD_W'(pcru_pkg::COORD_MAX);
      end else if (sum_x < pcru_pkg::COORD_MIN) begin
         sat_x = pcru_pkg::COORD_W'(pcru_pkg::COORD_MIN);
      end else begin
         sat_x = sum_x[pcru_pkg::COORD_W-1:0];
         ovf_x = 1'b0;
      end

      ovf_y = 1'b1;
      if (sum_y > pcru_pkg::COORD_MAX) begin
         sat_y = pcru_pkg::COORD_W'(pcru_pkg::COORD_MAX);
      end else if (sum_y < pcru_pkg::COORD_MIN) begin
         sat_y = pcru_pkg::COORD_W'(pcru_pkg::COORD_MIN);
      end else begin
         sat_y = sum_y[pcru_pkg::COORD_W-1:0];
         ovf_y = 1'b0;
      end

      ovf_r = 1'b0;
      if (s4_r_ff[DW-1]) begin
         sat_r = '0;
      end else if (s4_r_ff > pcru_pkg::RAD_MAX) begin
         sat_r = pcru_pkg::RAD_W'(pcru_pkg::RAD_MAX);
         ovf_r = 1'b1;
      end else begin
         sat_r = s4_r_ff[pcru_pkg::RAD_W-1:0];
      end

      s5_rsp_in = '0;
      unique case (s4_ctx_ff.opcode)
         pcru_pkg::OP_TO_POLAR,
         pcru_pkg::OP_DISTANCE: begin
            if (!s4_ctx_ff.zero) begin
               s5_rsp_in.radius_out = sat_r;
               s5_rsp_in.overflow   = ovf_r;
               if (s4_ctx_ff.opcode == pcru_pkg::OP_TO_POLAR) begin
                  s5_rsp_in.angle_out = s4_ang_ff;
               end
            end
         end
         pcru_pkg::OP_TO_POINT,
         pcru_pkg::OP_ROTATE_POINT,
         pcru_pkg::OP_ROTATE_AROUND,
         pcru_pkg::OP_TRANSLATE: begin
            s5_rsp_in.x_out    = sat_x;
            s5_rsp_in.y_out    = sat_y;
            s5_rsp_in.overflow = ovf_x | ovf_y;
         end
         default: begin
            // undefined opcode: drop everything to zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_rsp_ff <= s5_rsp_in;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = s5_rsp_ff;

endmodule

// ===== verif/tb_polar_cartesian_rotate_unit_core.sv =====
// Self-checking testbench for the polar/cartesian rotate unit: CORDIC predictor and scoreboard.
`timescale 1ns / 1ps

module tb_polar_cartesian_rotate_unit_core;
   import pcru_pkg::*;

   // opcodes with no defined operation; the unit must answer with all zeros
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int  CORDIC_STEPS = 24;
   localparam int  WORK_FRAC    = 24;
   localparam int  PIPE_DRAIN   = 40;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  RANDOM_WORDS = 700;
   localparam longint GAIN_COMP = 64'sd652032874;
   localparam longint RADIUS_TOP = 64'sd16777215;

   // arctangent of 2^-i, full turn = 2^32
   localparam longint ATAN_STEP [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_words[$];     // words waiting to be driven
   rsp_type expected_results[$];  // predicted results, oldest first

   int err_count    = 0;
   int cycle_count  = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int ovf_seen     = 0;

   polar_cartesian_rotate_unit_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Golden arithmetic
   // ---------------------------------------------------------------------

   // drop sh fraction bits, round half to even
   function automatic longint round_even(input longint v, input int sh);
      longint q;
      longint rem;
      longint half;
      q    = v >>> sh;
      rem  = v - (q <<< sh);
      half = longint'(1) <<< (sh - 1);
      if (rem > half || (rem == half && q[0]))
         q = q + 1;
      return q;
   endfunction

   function automatic longint clamp_coord(input longint v, inout logic ovf);
      if (v > longint'(COORD_MAX)) begin
         ovf = 1'b1;
         return longint'(COORD_MAX);
      end
      if (v < longint'(COORD_MIN)) begin
         ovf = 1'b1;
         return longint'(COORD_MIN);
      end
      return v;
   endfunction

   function automatic longint clamp_radius(input longint v, inout logic ovf);
      if (v < 0)
         return 0;
      if (v > RADIUS_TOP) begin
         ovf = 1'b1;
         return RADIUS_TOP;
      end
      return v;
   endfunction

   // integer coordinate to working fixed point with the gain removed
   function automatic longint to_work(input longint p);
      return (p * GAIN_COMP) >>> (30 - WORK_FRAC);
   endfunction

   // rotate (x, y) by a 32-bit binary angle; fold to the right half-plane first
   function automatic void cordic_turn(inout longint x, inout longint y,
                                       input logic [31:0] ang);
      longint z;
      longint xs;
      longint ys;
      logic [31:0] flipped;
      z = longint'($signed(ang));
      if (z > (longint'(1) <<< 30) || z < -(longint'(1) <<< 30)) begin
         x = -x;
         y = -y;
         flipped = ang + 32'h8000_0000;
         z = longint'($signed(flipped));
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP[i];
         end
      end
   endfunction

   // drive y to zero; leave the magnitude in rad and the angle in ang
   function automatic void cordic_measure(input longint x, input longint y,
                                          output longint rad, output logic [31:0] ang);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = longint'(1) <<< 31;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP[i];
         end
      end
      rad = x;
      ang = z[31:0];
   endfunction

   function automatic rsp_type predict_geometry(input req_type w);
      rsp_type res;
      longint ax, ay, bx, by, vr, x, y, r;
      logic [31:0] va, ra, a, a_rnd;
      logic ovf;
      ax  = longint'(w.first_x);
      ay  = longint'(w.first_y);
      bx  = longint'(w.second_x);
      by  = longint'(w.second_y);
      vr  = longint'(w.vertex_radius);
      va  = {w.vertex_angle, 16'h0000};
      ra  = {w.rotation_angle, 16'h0000};
      ovf = 1'b0;
      res = '0;
      case (w.opcode)
         OP_TO_POLAR: begin
            // the origin has no angle: leave radius and angle at zero
            if (ax != 0 || ay != 0) begin
               cordic_measure(to_work(ax), to_work(ay), r, a);
               res.radius_out = clamp_radius(round_even(r, WORK_FRAC - RAD_FRAC), ovf);
               a_rnd = a + 32'h0000_8000;
               res.angle_out = a_rnd[31:16];
            end
         end
         OP_TO_POINT, OP_ROTATE_AROUND: begin
            x = (vr * GAIN_COMP) >>> (30 + RAD_FRAC - WORK_FRAC);
            y = 0;
            cordic_turn(x, y, (w.opcode == OP_TO_POINT) ? va : va + ra);
            x = round_even(x, WORK_FRAC);
            y = round_even(y, WORK_FRAC);
            // round first, then add the origin; only the sum saturates
            if (w.opcode == OP_ROTATE_AROUND) begin
               x = x + bx;
               y = y + by;
            end
            res.x_out = clamp_coord(x, ovf);
            res.y_out = clamp_coord(y, ovf);
         end
         OP_ROTATE_POINT: begin
            x = to_work(ax);
            y = to_work(ay);
            cordic_turn(x, y, ra);
            res.x_out = clamp_coord(round_even(x, WORK_FRAC), ovf);
            res.y_out = clamp_coord(round_even(y, WORK_FRAC), ovf);
         end
         OP_TRANSLATE: begin
            res.x_out = clamp_coord(ax + bx, ovf);
            res.y_out = clamp_coord(ay + by, ovf);
         end
         OP_DISTANCE: begin
            if (ax != bx || ay != by) begin
               cordic_measure(to_work(bx - ax), to_work(by - ay), r, a);
               res.radius_out = clamp_radius(round_even(r, WORK_FRAC), ovf);
            end
         end
         default: ;
      endcase
      res.overflow = ovf;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_word(input logic [2:0] op,
                                         input int ax, input int ay,
                                         input int bx, input int by,
                                         input int rad, input int va, input int ra);
      req_type w;
      w.opcode         = op;
      w.first_x        = ax[15:0];
      w.first_y        = ay[15:0];
      w.second_x       = bx[15:0];
      w.second_y       = by[15:0];
      w.vertex_radius  = rad[23:0];
      w.vertex_angle   = va[15:0];
      w.rotation_angle = ra[15:0];
      return w;
   endfunction

   // append a word to the stimulus queue
   function automatic void queue_word(input req_type w);
      pending_words = {pending_words, w};
   endfunction

   // mostly uniform, sometimes an edge value
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 19))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'($urandom_range(0, 40)) - 16'd20;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 4)
         w.opcode = sel[0] ? OP_SPARE_HI : OP_SPARE_LO;
      else
         w.opcode = 3'($urandom_range(0, 5));
      w.first_x        = pick_coord();
      w.first_y        = pick_coord();
      w.second_x       = pick_coord();
      w.second_y       = pick_coord();
      w.vertex_angle   = pick_coord();
      w.rotation_angle = pick_coord();
      case ($urandom_range(0, 5))
         0: w.vertex_radius = 24'hFFFFFF;
         1: w.vertex_radius = 24'($urandom_range(0, 4095));
         2: w.vertex_radius = 24'($urandom_range(0, 2000)) + 24'h7FFC00;
         default: w.vertex_radius = 24'($urandom);
      endcase
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of words with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         // word taken: free the channel
         if (req_valid && req_ready)
            next_valid = 1'b0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (pending_words.size() > 0) begin
               next_data  = pending_words.pop_front();
               next_valid = 1'b1;
               words_sent = words_sent + 1;
               if (burst_left > 0) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // ---------------------------------------------------------------------
   // Receiver back-pressure: a mode per stretch of cycles
   // ---------------------------------------------------------------------
   int stall_mode = 0;
   int stall_span = 0;

   always @(posedge clock) begin
      logic next_ready;
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(5, 60);
      end else begin
         stall_span = stall_span - 1;
      end
      case (stall_mode)
         0:       next_ready = 1'b1;                          // free flowing
         1:       next_ready = ($urandom_range(0, 1) == 1);   // coin toss
         2:       next_ready = ($urandom_range(0, 7) == 0);   // heavy stall
         default: next_ready = ($urandom_range(0, 7) != 0);   // light stall
      endcase
      rsp_ready <= reset ? 1'b0 : next_ready;
   end

   // ---------------------------------------------------------------------
   // Monitor and scoreboard
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results = {expected_results, predict_geometry(req_data)};
         if (rsp_valid && rsp_ready) begin
            results_seen = results_seen + 1;
            if (rsp_data.overflow)
               ovf_seen = ovf_seen + 1;
            if (expected_results.size() == 0) begin
               $error("result word with nothing outstanding: %h", rsp_data);
               err_count = err_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.x_out !== want.x_out) begin
                  $error("x_out: expected %0d, got %0d", want.x_out, rsp_data.x_out);
                  err_count = err_count + 1;
               end
               if (rsp_data.y_out !== want.y_out) begin
                  $error("y_out: expected %0d, got %0d", want.y_out, rsp_data.y_out);
                  err_count = err_count + 1;
               end
               if (rsp_data.radius_out !== want.radius_out) begin
                  $error("radius_out: expected %0d, got %0d",
                         want.radius_out, rsp_data.radius_out);
                  err_count = err_count + 1;
               end
               if (rsp_data.angle_out !== want.angle_out) begin
                  $error("angle_out: expected %0d, got %0d",
                         want.angle_out, rsp_data.angle_out);
                  err_count = err_count + 1;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                  err_count = err_count + 1;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;

      // directed: edges of every operation
      queue_word(make_word(OP_TO_POLAR, 0, 0, 5, 5, 100, 1, 1));      // origin
      queue_word(make_word(OP_TO_POLAR, 32767, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TO_POLAR, -32768, -32768, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TO_POLAR, -1, 0, 0, 0, 0, 0, 0));       // angle pi
      queue_word(make_word(OP_TO_POLAR, 0, -7, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TO_POINT, 0, 0, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_TO_POINT, 0, 0, 0, 0, 24'hFFFFFF, 0, 0)); // saturate
      queue_word(make_word(OP_TO_POINT, 0, 0, 0, 0, 24'hFFFFFF, -32768, 0));
      queue_word(make_word(OP_TO_POINT, 0, 0, 0, 0, 128, 16384, 0));  // half LSB
      queue_word(make_word(OP_TO_POINT, 0, 0, 0, 0, 384, 32767, 0));
      queue_word(make_word(OP_ROTATE_POINT, 32767, 32767, 0, 0, 0, 0, 8192));
      queue_word(make_word(OP_ROTATE_POINT, -32768, 0, 0, 0, 0, 0, -32768));
      queue_word(make_word(OP_ROTATE_POINT, 100, -50, 0, 0, 0, 0, 0));
      queue_word(make_word(OP_ROTATE_AROUND, 0, 0, 32767, 32767,
                           24'hFFFFFF, 32767, 32767));            // angle wrap
      queue_word(make_word(OP_ROTATE_AROUND, 0, 0, -32768, -32768,
                           24'h7FFFFF, -32768, 0));
      queue_word(make_word(OP_ROTATE_AROUND, 0, 0, 32767, 0, 256, 0, 0));
      queue_word(make_word(OP_TRANSLATE, 32767, -32768, 1, -1, 0, 0, 0));
      queue_word(make_word(OP_TRANSLATE, -32768, 32767, -32768, 32767, 0, 0, 0));
      queue_word(make_word(OP_TRANSLATE, 12, -34, -12, 34, 0, 0, 0));
      queue_word(make_word(OP_DISTANCE, 9, -9, 9, -9, 0, 0, 0));     // same point
      queue_word(make_word(OP_DISTANCE, -32768, -32768, 32767, 32767, 0, 0, 0));
      queue_word(make_word(OP_DISTANCE, 32767, 0, -32768, 0, 0, 0, 0));
      queue_word(make_word(OP_DISTANCE, 0, 0, 3, 4, 0, 0, 0));
      queue_word(make_word(OP_SPARE_LO, -1, -1, -1, -1, 24'hFFFFFF, -1, -1));
      queue_word(make_word(OP_SPARE_HI, 32767, 1, 2, 3, 4, 5, 6));

      for (int n = 0; n < RANDOM_WORDS; n++)
         queue_word(random_word());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // hold until every word is out and every result is back
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);

      $display("run covered %0d words in, %0d results checked, %0d with overflow set",
               words_sent, results_seen, ovf_seen);
      $display("all six operations and both spare opcodes, under bursty input and stalls");
      if (err_count == 0 && expected_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pcru_pkg.sv
rtl/core/pcru_cordic_stage.sv
rtl/core/polar_cartesian_rotate_unit_core.sv
verif/tb_polar_cartesian_rotate_unit_core.sv
